// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent and consequent in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/ssid_pkg.sv =====
// types, codes and sizes for the sorted set table
// no dependencies
`timescale 1ns / 1ps

package ssid_pkg;

   localparam int TABLE_SIZE = 32;
   localparam int IDX_W      = $clog2(TABLE_SIZE);
   localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
   localparam int VAL_W      = 31;
   localparam int POS_W      = 5;
   localparam int UC_W       = 6;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_DELETE = 1'b1;

   typedef enum logic [2:0] {
      ST_INSERTED = 3'd0,
      ST_PRESENT  = 3'd1,
      ST_FULL     = 3'd2,
      ST_DELETED  = 3'd3,
      ST_NOTFOUND = 3'd4,
      ST_ZERO     = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_MOVE_RD,
      S_MOVE_WR,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic             kind;
      logic [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      status_type       status;
      logic [POS_W-1:0] position;
      logic [UC_W-1:0]  used_count;
   } rsp_type;

   typedef struct packed {
      logic equal;
      logic above;
   } step_flags_type;

endpackage

// ===== rtl/ssid_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module ssid_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ssid_step.sv =====
// shared index step and entry compare unit
// depends on ssid_pkg
`timescale 1ns / 1ps

module ssid_step (
   input  logic [ssid_pkg::CNT_W-1:0] operand,
   input  logic                       dec,
   input  logic [ssid_pkg::VAL_W-1:0] entry,
   input  logic [ssid_pkg::VAL_W-1:0] target,
   output logic [ssid_pkg::CNT_W-1:0] result,
   output ssid_pkg::step_flags_type   flags
);

   always_comb begin
      if (dec) begin
         result = operand - ssid_pkg::CNT_W'(1);
      end else begin
         result = operand + ssid_pkg::CNT_W'(1);
      end
      flags.equal = (entry == target);
      flags.above = (entry > target);
   end

endmodule

// ===== rtl/sorted_set_insert_delete.sv =====
// sorted set table top level: sequencer, index step unit and entry ram
// depends on ssid_pkg, ssid_step, ssid_ram
//
// channel   ports                      handshake
// request   req_data                   beat taken when start && !busy
// response  rsp_data                   one cycle beat on rsp_valid
//
// zero value: result in the cycle after the beat, busy stays low
// search: read then compare state per entry; one last read state at the count
// shift: read and write state per entry moved; finish writes the new or freed slot
// rsp_valid rises as busy falls; all table reads share the one ram read port
// reset is synchronous; table reads only touch slots below the count
// the receiver cannot stall, so rsp_valid lasts exactly one cycle
`timescale 1ns / 1ps

module sorted_set_insert_delete (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ssid_pkg::req_type req_data,
   output logic              rsp_valid,
   output ssid_pkg::rsp_type rsp_data
);

   ssid_pkg::state_type            state_ff, state_in;
   logic                           kind_ff, kind_in;
   logic [ssid_pkg::VAL_W-1:0]     val_ff, val_in;
   logic [ssid_pkg::CNT_W-1:0]     idx_ff, idx_in;
   logic [ssid_pkg::CNT_W-1:0]     ptr_ff, ptr_in;
   logic [ssid_pkg::CNT_W-1:0]     src_ff, src_in;
   logic [ssid_pkg::CNT_W-1:0]     count_ff, count_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   ssid_pkg::rsp_type              rsp_data_ff, rsp_data_in;

   logic                           ram_we;
   logic [ssid_pkg::IDX_W-1:0]     ram_waddr;
   logic [ssid_pkg::VAL_W-1:0]     ram_wdata;
   logic                           ram_re;
   logic [ssid_pkg::IDX_W-1:0]     ram_raddr;
   logic [ssid_pkg::VAL_W-1:0]     ram_rdata;

   logic [ssid_pkg::CNT_W-1:0]     step_op;
   logic                           step_dec;
   logic [ssid_pkg::CNT_W-1:0]     step_res;
   ssid_pkg::step_flags_type       step_flags;

   assign step_op  = (state_ff == ssid_pkg::S_MOVE_RD) ? ptr_ff : idx_ff;
   assign step_dec = (state_ff == ssid_pkg::S_MOVE_RD) && (kind_ff == ssid_pkg::KIND_INSERT);

   ssid_step u_step (
      .operand (step_op),
      .dec     (step_dec),
      .entry   (ram_rdata),
      .target  (val_ff),
      .result  (step_res),
      .flags   (step_flags)
   );

   ssid_ram #(
      .WIDTH (ssid_pkg::VAL_W),
      .DEPTH (ssid_pkg::TABLE_SIZE)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssid_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff     <= kind_in;
      val_ff      <= val_in;
      idx_ff      <= idx_in;
      ptr_ff      <= ptr_in;
      src_ff      <= src_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      val_in       = val_ff;
      idx_in       = idx_ff;
      ptr_in       = ptr_ff;
      src_in       = src_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = ptr_ff[ssid_pkg::IDX_W-1:0];
      ram_wdata    = ram_rdata;
      ram_re       = 1'b0;
      ram_raddr    = idx_ff[ssid_pkg::IDX_W-1:0];

      rsp_data_in.used_count = ssid_pkg::UC_W'(count_ff);
      rsp_data_in.position   = '0;

      case (state_ff)
         ssid_pkg::S_IDLE: begin
            rsp_data_in = rsp_data_ff;
            if (start) begin
               kind_in = req_data.kind;
               val_in  = req_data.value;
               idx_in  = '0;
               if (req_data.value == '0) begin
                  rsp_valid_in           = 1'b1;
                  rsp_data_in.status     = ssid_pkg::ST_ZERO;
                  rsp_data_in.position   = '0;
                  rsp_data_in.used_count = ssid_pkg::UC_W'(count_ff);
               end else begin
                  state_in = ssid_pkg::S_SRCH_RD;
               end
            end
         end

         ssid_pkg::S_SRCH_RD: begin
            if (idx_ff == count_ff) begin
               // absent, slot is the count
               if (kind_ff == ssid_pkg::KIND_DELETE) begin
                  rsp_valid_in       = 1'b1;
                  rsp_data_in.status = ssid_pkg::ST_NOTFOUND;
                  state_in           = ssid_pkg::S_IDLE;
               end else if (count_ff == ssid_pkg::CNT_W'(ssid_pkg::TABLE_SIZE)) begin
                  rsp_valid_in       = 1'b1;
                  rsp_data_in.status = ssid_pkg::ST_FULL;
                  state_in           = ssid_pkg::S_IDLE;
               end else begin
                  ptr_in   = count_ff;
                  state_in = ssid_pkg::S_MOVE_RD;
               end
            end else begin
               ram_re   = 1'b1;
               state_in = ssid_pkg::S_SRCH_CMP;
            end
         end

         ssid_pkg::S_SRCH_CMP: begin
            if (step_flags.equal) begin
               if (kind_ff == ssid_pkg::KIND_INSERT) begin
                  rsp_valid_in         = 1'b1;
                  rsp_data_in.status   = ssid_pkg::ST_PRESENT;
                  rsp_data_in.position = ssid_pkg::POS_W'(idx_ff);
                  state_in             = ssid_pkg::S_IDLE;
               end else begin
                  ptr_in   = idx_ff;
                  state_in = ssid_pkg::S_MOVE_RD;
               end
            end else if (step_flags.above) begin
               // sorted table: value absent, slot found
               if (kind_ff == ssid_pkg::KIND_DELETE) begin
                  rsp_valid_in       = 1'b1;
                  rsp_data_in.status = ssid_pkg::ST_NOTFOUND;
                  state_in           = ssid_pkg::S_IDLE;
               end else if (count_ff == ssid_pkg::CNT_W'(ssid_pkg::TABLE_SIZE)) begin
                  rsp_valid_in       = 1'b1;
                  rsp_data_in.status = ssid_pkg::ST_FULL;
                  state_in           = ssid_pkg::S_IDLE;
               end else begin
                  ptr_in   = count_ff;
                  state_in = ssid_pkg::S_MOVE_RD;
               end
            end else begin
               idx_in   = step_res;
               state_in = ssid_pkg::S_SRCH_RD;
            end
         end

         ssid_pkg::S_MOVE_RD: begin
            ram_raddr = step_res[ssid_pkg::IDX_W-1:0];
            src_in    = step_res;
            if (kind_ff == ssid_pkg::KIND_INSERT) begin
               if (ptr_ff == idx_ff) begin
                  state_in = ssid_pkg::S_FINISH;
               end else begin
                  ram_re   = 1'b1;
                  state_in = ssid_pkg::S_MOVE_WR;
               end
            end else begin
               if (step_res == count_ff) begin
                  state_in = ssid_pkg::S_FINISH;
               end else begin
                  ram_re   = 1'b1;
                  state_in = ssid_pkg::S_MOVE_WR;
               end
            end
         end

         ssid_pkg::S_MOVE_WR: begin
            ram_we   = 1'b1;
            ptr_in   = src_ff;
            state_in = ssid_pkg::S_MOVE_RD;
         end

         ssid_pkg::S_FINISH: begin
            ram_we               = 1'b1;
            rsp_valid_in         = 1'b1;
            rsp_data_in.position = ssid_pkg::POS_W'(idx_ff);
            state_in             = ssid_pkg::S_IDLE;
            if (kind_ff == ssid_pkg::KIND_INSERT) begin
               ram_wdata              = val_ff;
               count_in               = count_ff + ssid_pkg::CNT_W'(1);
               rsp_data_in.status     = ssid_pkg::ST_INSERTED;
               rsp_data_in.used_count = ssid_pkg::UC_W'(count_ff + ssid_pkg::CNT_W'(1));
            end else begin
               ram_wdata              = '0;
               count_in               = count_ff - ssid_pkg::CNT_W'(1);
               rsp_data_in.status     = ssid_pkg::ST_DELETED;
               rsp_data_in.used_count = ssid_pkg::UC_W'(count_ff - ssid_pkg::CNT_W'(1));
            end
         end

         default: begin
            state_in = ssid_pkg::S_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != ssid_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/ssid_checker.sv =====
// port level checks for the sorted set table, bound to the top level
// depends on ssid_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ssid_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input ssid_pkg::req_type req_data,
   input logic              rsp_valid,
   input ssid_pkg::rsp_type rsp_data
);

   logic req_beat;
   logic no_pos;
   logic zero_beat;
   logic zero_rsp;
   logic ins_rsp;
   logic count_ok;

   assign req_beat  = start && !busy;
   assign no_pos    = (rsp_data.status == ssid_pkg::ST_FULL) ||
                      (rsp_data.status == ssid_pkg::ST_NOTFOUND) ||
                      (rsp_data.status == ssid_pkg::ST_ZERO);
   assign zero_beat = req_beat && (req_data.value == '0);
   assign zero_rsp  = rsp_valid && (rsp_data.status == ssid_pkg::ST_ZERO);
   assign ins_rsp   = rsp_valid && (rsp_data.status == ssid_pkg::ST_INSERTED);
   assign count_ok  = rsp_data.used_count <= ssid_pkg::UC_W'(ssid_pkg::TABLE_SIZE);

   `ASSERT_NEXT(a_beat_answered, clock, reset, req_beat, busy || rsp_valid)
   `ASSERT_NEXT(a_zero_fast, clock, reset, zero_beat, zero_rsp)
   `ASSERT_SAME(a_no_position, clock, reset, rsp_valid && no_pos, rsp_data.position == '0)
   `ASSERT_SAME(a_insert_count, clock, reset, ins_rsp, rsp_data.used_count != '0)
   `ASSERT_SAME(a_count_range, clock, reset, rsp_valid, count_ok)

endmodule

bind sorted_set_insert_delete ssid_checker u_ssid_checker (.*);

// ===== test/tb_sorted_set_insert_delete.sv =====
// self-checking testbench for the sorted set table with insert and delete
// depends on ssid_pkg and sorted_set_insert_delete; predicts each response from its own table copy
`timescale 1ns / 1ps

module tb_sorted_set_insert_delete;

   import ssid_pkg::*;

   localparam int MAX_CYCLES   = 400000;
   localparam int TAIL_CYCLES  = 100;
   localparam int POOL_SIZE    = 48;
   localparam int RANDOM_ITEMS = 600;
   localparam int PHASE_ITEMS  = 100;
   localparam int QUIET_ITEMS  = 100;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      req_type req;
      rsp_type rsp;
   } awaited_beat_type;

   class set_table_predictor;
      bit [VAL_W-1:0]   slots[TABLE_SIZE];
      int               used;
      int               mismatches;
      awaited_beat_type awaited[$];

      function new();
         used = 0;
         mismatches = 0;
         foreach (slots[i]) slots[i] = '0;
      endfunction

      function void take_request(req_type r);
         awaited_beat_type x;
         int hit;
         int at;
         int i;
         x.req = r;
         x.rsp = '0;
         hit = used;
         for (i = used - 1; i >= 0; i--) begin
            if (slots[i] == r.value) hit = i;
         end
         if (r.value == '0) begin
            x.rsp.status = ST_ZERO;
         end else if (r.kind == KIND_INSERT) begin
            if (hit < used) begin
               x.rsp.status = ST_PRESENT;
               x.rsp.position = hit[POS_W-1:0];
            end else if (used >= TABLE_SIZE) begin
               x.rsp.status = ST_FULL;
            end else begin
               at = 0;
               while (at < used && r.value > slots[at]) at++;
               for (i = used; i > at; i--) slots[i] = slots[i-1];
               slots[at] = r.value;
               used++;
               x.rsp.status = ST_INSERTED;
               x.rsp.position = at[POS_W-1:0];
            end
         end else begin
            if (hit >= used) begin
               x.rsp.status = ST_NOTFOUND;
            end else begin
               for (i = hit; i + 1 < used; i++) slots[i] = slots[i+1];
               slots[used-1] = '0;
               used--;
               x.rsp.status = ST_DELETED;
               x.rsp.position = hit[POS_W-1:0];
            end
         end
         x.rsp.used_count = used[UC_W-1:0];
         awaited.push_back(x);
      endfunction

      function void check_result(rsp_type got);
         awaited_beat_type x;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected response: status %0d pos %0d count %0d",
                        got.status, got.position, got.used_count);
         end else begin
            x = awaited.pop_front();
            if (got.status !== x.rsp.status || got.position !== x.rsp.position ||
                got.used_count !== x.rsp.used_count) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("mismatch: kind %0d value %0d exp %0d/%0d/%0d got %0d/%0d/%0d",
                           x.req.kind, x.req.value, x.rsp.status, x.rsp.position,
                           x.rsp.used_count, got.status, got.position, got.used_count);
            end
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   set_table_predictor tracker;
   logic [VAL_W-1:0]   pool[POOL_SIZE];
   int                 cycle_count = 0;

   sorted_set_insert_delete dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   task automatic send_beat(input logic kind, input logic [VAL_W-1:0] value, input int gap);
      req_type r;
      r.kind = kind;
      r.value = value;
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy !== 1'b0);
      tracker.take_request(r);
   endtask

   task automatic pause_until_drained();
      @(negedge clock);
      start <= 1'b0;
      while (tracker.pending() > 0) @(posedge clock);
   endtask

   function automatic logic [VAL_W-1:0] pick_value();
      int          roll;
      logic [31:0] raw;
      roll = $urandom_range(0, 99);
      raw = $urandom();
      if (roll < 80) return pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (roll < 92) return raw[VAL_W-1:0];
      else if (roll < 96) return '0;
      else return VAL_W'($urandom_range(1, 4));
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) tracker.check_result(rsp_data);
   end

   initial begin
      while (cycle_count < MAX_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int          n;
      int          gap;
      bit          filling;
      logic        kind;
      logic [31:0] raw;
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      tracker = new();
      pool[0] = VAL_W'(1);
      pool[1] = {VAL_W{1'b1}};
      for (n = 2; n < POOL_SIZE; n++) begin
         raw = $urandom();
         pool[n] = (raw[VAL_W-1:0] == '0) ? VAL_W'(2) : raw[VAL_W-1:0];
      end
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed: zero, empty table, ends, middle, present, absent
      send_beat(KIND_INSERT, '0, 0);
      send_beat(KIND_DELETE, '0, 0);
      send_beat(KIND_DELETE, 31'd5, 0);
      send_beat(KIND_INSERT, 31'd100, 0);
      send_beat(KIND_INSERT, 31'h7fff_ffff, 0);
      send_beat(KIND_INSERT, 31'd1, 0);
      send_beat(KIND_INSERT, 31'd50, 0);
      send_beat(KIND_INSERT, 31'd100, 0);
      send_beat(KIND_INSERT, 31'd1, 0);
      send_beat(KIND_INSERT, '0, 0);
      send_beat(KIND_DELETE, 31'd777, 0);
      send_beat(KIND_DELETE, 31'h7fff_ffff, 0);
      send_beat(KIND_DELETE, 31'd1, 0);
      send_beat(KIND_DELETE, 31'd50, 0);
      send_beat(KIND_INSERT, 31'h2aaa_aaaa, 0);
      send_beat(KIND_INSERT, 31'h5555_5555, 0);
      send_beat(KIND_DELETE, 31'd100, 0);
      send_beat(KIND_DELETE, 31'h2aaa_aaaa, 0);
      send_beat(KIND_DELETE, 31'h5555_5555, 0);
      send_beat(KIND_DELETE, 31'h5555_5555, 0);

      // alternate fill and drain phases so the table reaches full and empty
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % PHASE_ITEMS == 0) pause_until_drained();
         filling = ((n / PHASE_ITEMS) % 2 == 0);
         if (filling) kind = ($urandom_range(0, 99) < 90) ? KIND_INSERT : KIND_DELETE;
         else kind = ($urandom_range(0, 99) < 10) ? KIND_INSERT : KIND_DELETE;
         gap = 0;
         if (n < RANDOM_ITEMS - QUIET_ITEMS && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 3);
         send_beat(kind, pick_value(), gap);
      end

      @(negedge clock);
      start <= 1'b0;
      while (tracker.pending() > 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
